// ===== design/i2cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Shared types and constants for the i2c master bit sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

    localparam int BYTE_BITS = 8;
    localparam logic [2:0] LAST_BIT = 3'(BYTE_BITS - 1);

    // command codes
    typedef enum logic [2:0] {
        FUNC_START    = 3'd0,
        FUNC_STOP     = 3'd1,
        FUNC_WRITE    = 3'd2,
        FUNC_READ     = 3'd3,
        FUNC_SEND_ACK = 3'd4,
        FUNC_READ_ACK = 3'd5
    } func_t;

    // one pin assignment per phase
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SDA_HIGH,
        OP_SDA_LOW,
        OP_SDA_TX,
        OP_SDA_ACK,
        OP_SCL_HIGH,
        OP_SCL_LOW
    } pin_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_BITS
    } state_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic [7:0] line_bits;
    } in_word_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] rx_byte;
        logic       ack_in;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic    load;
        logic    emit;
        pin_op_t op;
        logic    sample;
        logic    last;
    } dp_cmd_t;

    typedef struct packed {
        logic  out_free;
        func_t func;
    } dp_status_t;

endpackage

// ===== design/i2cbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2cbs_ctrl
// Phase sequencer: walks each command through its pin phases.
// ----------------------------------------------------------------------------
module i2cbs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [2:0]            in_func,
    input  i2cbs_pkg::dp_status_t status,
    output logic                  in_ready,
    output i2cbs_pkg::dp_cmd_t    cmd
);
    import i2cbs_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic [2:0] bit_reg, bit_next;
    logic       bit_done;

    // write uses three phases per bit, read two
    assign bit_done = (status.func == FUNC_WRITE) ? (step_reg == 2'd2) : (step_reg == 2'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            bit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            bit_reg   <= bit_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    step_next = '0;
                    bit_next  = '0;
                    unique case (func_t'(in_func))
                        FUNC_WRITE:    state_next = ST_BITS;
                        FUNC_START,
                        FUNC_STOP,
                        FUNC_READ,
                        FUNC_SEND_ACK,
                        FUNC_READ_ACK: state_next = ST_RUN;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RUN: begin
                if (status.out_free) begin
                    if (cmd.last) begin
                        state_next = ST_IDLE;
                    end else if (status.func == FUNC_READ) begin
                        state_next = ST_BITS;
                        step_next  = '0;
                    end else begin
                        step_next = step_reg + 2'd1;
                    end
                end
            end
            ST_BITS: begin
                if (status.out_free) begin
                    if (cmd.last) begin
                        state_next = ST_IDLE;
                    end else if (bit_done) begin
                        step_next = '0;
                        bit_next  = bit_reg + 3'd1;
                    end else begin
                        step_next = step_reg + 2'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.sample = 1'b0;
        cmd.last   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RUN: begin
                cmd.emit = status.out_free;
                unique case (status.func)
                    FUNC_START: begin
                        unique case (step_reg)
                            2'd0:    cmd.op = OP_SDA_HIGH;
                            2'd1:    cmd.op = OP_SCL_HIGH;
                            2'd2:    cmd.op = OP_SDA_LOW;
                            default: cmd.op = OP_SCL_LOW;
                        endcase
                        cmd.last = (step_reg == 2'd3);
                    end
                    FUNC_STOP: begin
                        unique case (step_reg)
                            2'd0:    cmd.op = OP_SDA_LOW;
                            2'd1:    cmd.op = OP_SCL_HIGH;
                            default: cmd.op = OP_SDA_HIGH;
                        endcase
                        cmd.last = (step_reg == 2'd2);
                    end
                    FUNC_READ: begin
                        // release data line before clocking the byte in
                        cmd.op = OP_SDA_HIGH;
                    end
                    FUNC_SEND_ACK: begin
                        unique case (step_reg)
                            2'd0:    cmd.op = OP_SDA_ACK;
                            2'd1:    cmd.op = OP_SCL_HIGH;
                            default: cmd.op = OP_SCL_LOW;
                        endcase
                        cmd.last = (step_reg == 2'd2);
                    end
                    FUNC_READ_ACK: begin
                        unique case (step_reg)
                            2'd0:    cmd.op = OP_SDA_HIGH;
                            2'd1:    cmd.op = OP_SCL_HIGH;
                            default: cmd.op = OP_SCL_LOW;
                        endcase
                        cmd.last = (step_reg == 2'd2);
                    end
                    default: cmd.op = OP_NONE;
                endcase
            end
            ST_BITS: begin
                cmd.emit = status.out_free;
                if (status.func == FUNC_WRITE) begin
                    unique case (step_reg)
                        2'd0:    cmd.op = OP_SDA_TX;
                        2'd1:    cmd.op = OP_SCL_HIGH;
                        default: cmd.op = OP_SCL_LOW;
                    endcase
                end else begin
                    // sample while clock is high
                    cmd.op     = (step_reg == 2'd0) ? OP_SCL_HIGH : OP_SCL_LOW;
                    cmd.sample = (step_reg == 2'd0);
                end
                cmd.last = bit_done && (bit_reg == LAST_BIT);
            end
            default: in_ready = 1'b0;
        endcase
    end

endmodule

// ===== design/i2cbs_datapath.sv =====
// ----------------------------------------------------------------------------
// i2cbs_datapath
// Pin levels, byte shifter and result register.
// ----------------------------------------------------------------------------
module i2cbs_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  i2cbs_pkg::in_word_t    in_data,
    input  i2cbs_pkg::dp_cmd_t     cmd,
    output i2cbs_pkg::dp_status_t  status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output i2cbs_pkg::out_word_t   out_data
);
    import i2cbs_pkg::*;

    logic      scl_level_reg, scl_level_next;
    logic      sda_level_reg, sda_level_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] line_reg, line_next;
    func_t     func_reg;
    logic      ack_out_reg;
    logic      m_valid_reg;
    out_word_t m_data_reg, m_data_next;
    logic      out_free;

    assign out_free        = !m_valid_reg || out_ready;
    assign status.out_free = out_free;
    assign status.func     = func_reg;
    assign out_valid       = m_valid_reg;
    assign out_data        = m_data_reg;

    // apply one pin phase
    always_comb begin
        scl_level_next = scl_level_reg;
        sda_level_next = sda_level_reg;
        shift_next     = shift_reg;
        line_next      = line_reg;
        unique case (cmd.op)
            OP_SDA_HIGH: sda_level_next = 1'b1;
            OP_SDA_LOW:  sda_level_next = 1'b0;
            OP_SDA_TX: begin
                sda_level_next = shift_reg[7];
                shift_next     = {shift_reg[6:0], 1'b0};
            end
            OP_SDA_ACK:  sda_level_next = ack_out_reg;
            OP_SCL_HIGH: scl_level_next = 1'b1;
            OP_SCL_LOW:  scl_level_next = 1'b0;
            default:     scl_level_next = scl_level_reg;
        endcase
        if (cmd.sample) begin
            shift_next = {shift_reg[6:0], line_reg[7]};
            line_next  = {line_reg[6:0], 1'b0};
        end
        m_data_next.scl     = scl_level_next;
        m_data_next.sda     = sda_level_next;
        m_data_next.rx_byte = (cmd.last && func_reg == FUNC_READ) ? shift_reg : 8'd0;
        m_data_next.ack_in  = cmd.last && (func_reg == FUNC_READ_ACK) && line_reg[7];
        m_data_next.last    = cmd.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scl_level_reg <= 1'b1;
            sda_level_reg <= 1'b1;
            shift_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                if (func_t'(in_data.func) == FUNC_WRITE) begin
                    shift_reg <= in_data.tx_byte;
                end else if (func_t'(in_data.func) == FUNC_READ) begin
                    shift_reg <= '0;
                end
            end else if (cmd.emit) begin
                shift_reg <= shift_next;
            end
            if (cmd.emit) begin
                scl_level_reg <= scl_level_next;
                sda_level_reg <= sda_level_next;
                m_valid_reg   <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg    <= func_t'(in_data.func);
            ack_out_reg <= in_data.ack_out;
            line_reg    <= in_data.line_bits;
        end else if (cmd.emit) begin
            line_reg <= line_next;
        end
        if (cmd.emit) begin
            m_data_reg <= m_data_next;
        end
    end

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free)
        else $error("phase issued while result register is full");

    a_one_pin_per_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> !((scl_level_reg != $past(scl_level_reg)) &&
                       (sda_level_reg != $past(sda_level_reg))))
        else $error("both pins changed in one phase");

    a_rx_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.rx_byte != 8'd0)) |-> m_data_reg.last)
        else $error("received byte on a non-final phase");

    a_ack_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.ack_in) |-> m_data_reg.last)
        else $error("ack bit on a non-final phase");

endmodule

// ===== design/i2c_master_bit_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master pin sequencer: one command word in, one result word per pin phase.
// ----------------------------------------------------------------------------
//  channel | ports            | word contents
//  --------+------------------+-----------------------------------------------
//  input   | s_valid/s_ready  | func, tx_byte, ack_out, line_bits
//  result  | m_valid/m_ready  | scl, sda, rx_byte, ack_in, last
//
//  one result word per cycle within a command while the result side takes them;
//  a command holds the sequencer until the last of its phases is out: start 4,
//  stop 3, write 24, read 17, send ack 3, read ack 3 phases
//  undefined func codes are taken and give no result
//  reset (aresetn low, synchronous) releases both pins high and empties the
//  result register; a stalled result side holds the phase counter in place
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    // command words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  i2cbs_pkg::in_word_t  s_data,
    // phase result words
    output logic                 m_valid,
    input  logic                 m_ready,
    output i2cbs_pkg::out_word_t m_data
);
    import i2cbs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: state, phase step and bit counter
    i2cbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_func  (s_data.func),
        .status   (status),
        .in_ready (s_ready),
        .cmd      (cmd)
    );

    // pin levels, shifter and registered result word
    i2cbs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// ===== tb/i2c_master_bit_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_tb
// Self-checking bench: command words go in, every pin-phase word that comes
// out is compared against a cycle-free predictor of the sda/scl sequence.
// ----------------------------------------------------------------------------
import i2cbs_pkg::*;

// predicts the pin-phase words of each accepted command and checks them in order
class i2c_phase_scoreboard;
    bit        scl_lvl;
    bit        sda_lvl;
    bit [7:0]  shreg;
    bit [2:0]  bitcnt;
    out_word_t phase_q[$];
    int        errors;
    int        words_checked;

    function new();
        scl_lvl       = 1'b1;
        sda_lvl       = 1'b1;
        shreg         = '0;
        bitcnt        = '0;
        errors        = 0;
        words_checked = 0;
    endfunction

    function int pending();
        return phase_q.size();
    endfunction

    function void push_pins();
        out_word_t p;
        p     = '0;
        p.scl = scl_lvl;
        p.sda = sda_lvl;
        phase_q.push_back(p);
    endfunction

    function void drive_sda(bit v);
        sda_lvl = v;
        push_pins();
    endfunction

    function void drive_scl(bit v);
        scl_lvl = v;
        push_pins();
    endfunction

    function void note_command(in_word_t w);
        bit [7:0]  rx;
        bit        ack;
        out_word_t tail;
        rx  = '0;
        ack = 1'b0;
        case (w.func)
            FUNC_START: begin
                drive_sda(1'b1);
                drive_scl(1'b1);
                drive_sda(1'b0);
                drive_scl(1'b0);
            end
            FUNC_STOP: begin
                drive_sda(1'b0);
                drive_scl(1'b1);
                drive_sda(1'b1);
            end
            FUNC_WRITE: begin
                shreg  = w.tx_byte;
                bitcnt = '0;
                for (int i = 0; i < BYTE_BITS; i++) begin
                    drive_sda(shreg[7]);
                    shreg = shreg << 1;
                    drive_scl(1'b1);
                    drive_scl(1'b0);
                    bitcnt = bitcnt + 3'd1;
                end
            end
            FUNC_READ: begin
                shreg  = '0;
                bitcnt = '0;
                drive_sda(1'b1);
                for (int i = 0; i < BYTE_BITS; i++) begin
                    drive_scl(1'b1);
                    shreg = {shreg[6:0], w.line_bits[7 - i]};
                    drive_scl(1'b0);
                    bitcnt = bitcnt + 3'd1;
                end
                rx = shreg;
            end
            FUNC_SEND_ACK: begin
                drive_sda(w.ack_out);
                drive_scl(1'b1);
                drive_scl(1'b0);
            end
            FUNC_READ_ACK: begin
                drive_sda(1'b1);
                drive_scl(1'b1);
                ack = w.line_bits[7];
                drive_scl(1'b0);
            end
            default: return;
        endcase
        // final phase carries the received data and the last flag
        tail         = phase_q.pop_back();
        tail.rx_byte = rx;
        tail.ack_in  = ack;
        tail.last    = 1'b1;
        phase_q.push_back(tail);
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("word %0d: %s mismatch: expected %0h, got %0h",
                   words_checked, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_word(out_word_t got);
        out_word_t exp_w;
        if (phase_q.size() == 0) begin
            $error("unexpected result word %0h with nothing outstanding", got);
            errors++;
            return;
        end
        exp_w = phase_q.pop_front();
        compare_field("scl", exp_w.scl, got.scl);
        compare_field("sda", exp_w.sda, got.sda);
        compare_field("rx_byte", exp_w.rx_byte, got.rx_byte);
        compare_field("ack_in", exp_w.ack_in, got.ack_in);
        compare_field("last", exp_w.last, got.last);
        words_checked++;
    endfunction
endclass

module i2c_master_bit_sequencer_tb;

    // codes the sequencer must swallow without any result
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS   = 105;
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake at all
    localparam int TAIL_CYCLES    = 30;     // longest command plus the take cycle, with margin

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    i2c_master_bit_sequencer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    i2c_phase_scoreboard sb = new();

    int src_idle_pct;   // chance per cycle that the command side holds off
    int dst_stall_pct;  // chance per cycle that the result side stalls
    int cmd_sent;       // commands that give results, ignored codes left out
    int cmd_count [8];
    int quiet_cycles;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side back-pressure, changes on the falling edge only
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= dst_stall_pct);
    end

    // monitor: both handshakes sampled at the rising edge, plus the watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            // a new command's phases queue up behind any older ones still pending
            if (s_valid && s_ready) begin
                sb.note_command(s_data);
                cmd_count[s_data.func]++;
            end
            if (m_valid && m_ready) begin
                sb.check_word(m_data);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
                    $display("FAIL i2c_master_bit_sequencer");
                    $finish;
                end
            end
        end
    end

    function automatic in_word_t make_word(logic [2:0] f, logic [7:0] tx, logic ak,
                                           logic [7:0] ln);
        in_word_t w;
        w.func      = f;
        w.tx_byte   = tx;
        w.ack_out   = ak;
        w.line_bits = ln;
        return w;
    endfunction

    // command with every other field random, so unused fields still toggle
    function automatic in_word_t rand_word(logic [2:0] f);
        return make_word(f, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
    endfunction

    // entered and left at a falling edge; valid stays up across back-to-back words
    task automatic send_word(in_word_t w);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            s_data  <= rand_word(3'($urandom_range(0, 7)));
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (w.func <= FUNC_READ_ACK) cmd_sent++;
        @(negedge aclk);
    endtask

    // hold off the command side until every predicted phase has come out
    task automatic wait_all_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic set_idling(int ph);
        case (ph)
            0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
            1: begin src_idle_pct = 73; dst_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  dst_stall_pct = 73; end
            default: begin src_idle_pct = 25; dst_stall_pct = 25; end
        endcase
    endtask

    // well-formed bus transfer: start, address, ack, one to three data bytes, stop
    task automatic send_transfer();
        logic     reading;
        int       nbytes;
        in_word_t w;
        reading = 1'($urandom_range(0, 1));
        nbytes  = $urandom_range(1, 3);
        send_word(rand_word(FUNC_START));
        w            = rand_word(FUNC_WRITE);
        w.tx_byte[0] = reading;
        send_word(w);
        send_word(rand_word(FUNC_READ_ACK));
        for (int i = 0; i < nbytes; i++) begin
            if (reading) begin
                send_word(rand_word(FUNC_READ));
                // master nacks the final byte
                w         = rand_word(FUNC_SEND_ACK);
                w.ack_out = (i == nbytes - 1);
                send_word(w);
            end else begin
                send_word(rand_word(FUNC_WRITE));
                send_word(rand_word(FUNC_READ_ACK));
            end
        end
        send_word(rand_word(FUNC_STOP));
    endtask

    initial begin
        int rand_base;
        int ph;
        int cur_ph;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        quiet_cycles = 0;
        cmd_sent     = 0;
        set_idling(0);
        foreach (cmd_count[i]) cmd_count[i] = 0;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: every command, field extremes, spare codes
        send_word(make_word(FUNC_START, 8'h00, 1'b0, 8'h00));
        send_word(make_word(FUNC_WRITE, 8'h00, 1'b0, 8'h00));
        send_word(make_word(FUNC_WRITE, 8'hFF, 1'b1, 8'hFF));
        send_word(make_word(FUNC_WRITE, 8'hA5, 1'b0, 8'h5A));
        send_word(make_word(FUNC_READ_ACK, 8'h00, 1'b0, 8'h00));
        send_word(make_word(FUNC_READ_ACK, 8'hFF, 1'b1, 8'hFF));
        send_word(make_word(FUNC_READ_ACK, 8'h00, 1'b0, 8'h7F));
        send_word(make_word(FUNC_READ, 8'h00, 1'b0, 8'h00));
        send_word(make_word(FUNC_READ, 8'hFF, 1'b1, 8'hFF));
        send_word(make_word(FUNC_READ, 8'h00, 1'b0, 8'h5A));
        send_word(make_word(FUNC_READ, 8'hFF, 1'b1, 8'h81));
        send_word(make_word(FUNC_SEND_ACK, 8'hFF, 1'b0, 8'hFF));
        send_word(make_word(FUNC_SEND_ACK, 8'h00, 1'b1, 8'h00));
        // spare codes in the middle of a transfer must leave the pins alone
        send_word(make_word(FUNC_SPARE_6, 8'hFF, 1'b1, 8'hFF));
        send_word(make_word(FUNC_SPARE_7, 8'h00, 1'b0, 8'h00));
        send_word(make_word(FUNC_STOP, 8'hFF, 1'b1, 8'hFF));
        send_word(make_word(FUNC_STOP, 8'h00, 1'b0, 8'h00));
        send_word(make_word(FUNC_START, 8'hFF, 1'b1, 8'hFF));
        send_word(make_word(FUNC_START, 8'h00, 1'b0, 8'h00));
        send_word(make_word(FUNC_SPARE_7, 8'hFF, 1'b1, 8'hFF));
        send_word(make_word(FUNC_STOP, 8'h3C, 1'b1, 8'hC3));
        wait_all_results();

        // random: mostly legal transfers, some loose commands and spare codes,
        // with the idling mode stepping through its phases as the count grows
        rand_base = cmd_sent;
        cur_ph    = 0;
        while (cmd_sent - rand_base < RANDOM_ITEMS) begin
            ph = (cmd_sent - rand_base) * 4 / RANDOM_ITEMS;
            if (ph > 3) ph = 3;
            if (ph != cur_ph) begin
                wait_all_results();
                set_idling(ph);
                cur_ph = ph;
            end
            if ($urandom_range(0, 99) < 80) begin
                send_transfer();
            end else begin
                send_word(rand_word(3'($urandom_range(0, 7))));
            end
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (sb.pending() != 0) begin
            $error("%0d result words never arrived", sb.pending());
            sb.errors++;
        end

        $display("covered %0d start, %0d stop, %0d write, %0d read, %0d ack out, %0d ack in,",
                 cmd_count[FUNC_START], cmd_count[FUNC_STOP], cmd_count[FUNC_WRITE],
                 cmd_count[FUNC_READ], cmd_count[FUNC_SEND_ACK], cmd_count[FUNC_READ_ACK]);
        $display("%0d spare codes; %0d phase words checked across four idling modes",
                 cmd_count[FUNC_SPARE_6] + cmd_count[FUNC_SPARE_7], sb.words_checked);

        if (sb.errors == 0) begin
            $display("PASS i2c_master_bit_sequencer");
        end else begin
            $display("FAIL i2c_master_bit_sequencer");
        end
        $finish;
    end

endmodule
